/* rtl/core/dfa_pkg.sv */
// shared constants for the double float adder
package dfa_pkg;
  localparam int unsigned ExpW  = 11;
  localparam int unsigned FracW = 52;
  localparam int unsigned SigW  = FracW + 1;
  localparam int unsigned ShW   = $clog2(SigW + 1);
  localparam logic [ExpW-1:0] ExpAllOnes = {ExpW{1'b1}};
endpackage

/* rtl/core/double_float_adder_top.sv */
// top level of the truncating double precision adder
//
//  channel | signals                         | direction
//  in      | in_valid_i in_ready_o a, b      | into block
//  out     | out_valid_o out_ready_i sum     | out of block
//
// one item enters per cycle while in_ready_o is high; it passes the operand register, then the result register
// rst_ni clears only the valid flags; payload registers carry no reset
// a stalled result holds in the result register; the operand stage advances
// whenever the result register is empty or being emptied
module double_float_adder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] operand_a_i,
  input  logic [63:0] operand_b_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] sum_bits_o
);
  localparam int unsigned EW = dfa_pkg::ExpW;
  localparam int unsigned FW = dfa_pkg::FracW;
  localparam int unsigned SW = dfa_pkg::SigW;

  logic        s1_valid_q, out_valid_q;
  logic [63:0] a_q, b_q, sum_q, sum_d;
  logic        s1_adv;

  // pipeline flow control
  assign s1_adv     = ~out_valid_q | out_ready_i;
  assign in_ready_o = ~s1_valid_q | s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) s1_valid_q <= in_valid_i;
      if (s1_adv) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      a_q <= operand_a_i;
      b_q <= operand_b_i;
    end
    if (s1_adv && s1_valid_q) sum_q <= sum_d;
  end

  // datapath between operand and result registers
  logic [EW-1:0] ea, eb, e_big, e_sml;
  logic [SW-1:0] ma, mb, m_big, m_sml, m_al, diff;
  logic [SW:0]   addsum;
  logic          swap, s_big, s_sml;
  logic [EW-1:0] d;
  logic [dfa_pkg::ShW-1:0] lz;
  logic [EW+1:0] e_work;
  logic [SW-1:0] norm;

  assign ea = a_q[62:52];
  assign eb = b_q[62:52];
  assign ma = {1'b1, a_q[FW-1:0]};
  assign mb = {1'b1, b_q[FW-1:0]};
  assign swap  = (eb > ea) || ((eb == ea) && (mb > ma));
  assign e_big = swap ? eb : ea;
  assign e_sml = swap ? ea : eb;
  assign m_big = swap ? mb : ma;
  assign m_sml = swap ? ma : mb;
  assign s_big = swap ? b_q[63] : a_q[63];
  assign s_sml = swap ? a_q[63] : b_q[63];
  assign d     = e_big - e_sml;
  // shifts of the significand width or more clear it
  assign m_al  = (d >= EW'(SW)) ? '0 : (m_sml >> d);
  assign addsum = {1'b0, m_big} + {1'b0, m_al};
  assign diff   = m_big - m_al;

  dfa_lzc u_lzc (.value_i(diff), .count_o(lz));

  always_comb begin
    norm   = '0;
    e_work = '0;
    if (ea == dfa_pkg::ExpAllOnes)      sum_d = a_q;
    else if (eb == dfa_pkg::ExpAllOnes) sum_d = b_q;
    else if (ea == '0)                  sum_d = b_q;
    else if (eb == '0)                  sum_d = a_q;
    else if (s_big == s_sml) begin
      norm   = addsum[SW] ? addsum[SW:1] : addsum[SW-1:0];
      e_work = {2'b00, e_big} + {{(EW+1){1'b0}}, addsum[SW]};
      if (e_work >= {2'b00, dfa_pkg::ExpAllOnes})
        sum_d = {s_big, dfa_pkg::ExpAllOnes, {FW{1'b0}}};
      else
        sum_d = {s_big, e_work[EW-1:0], norm[FW-1:0]};
    end else if (diff == '0) begin
      sum_d = '0;
    end else begin
      norm   = diff << lz;
      e_work = {2'b00, e_big} - {{(EW+2-dfa_pkg::ShW){1'b0}}, lz};
      // borrow or zero means underflow
      if (e_work[EW+1] || e_work == '0)
        sum_d = {s_big, {(EW+FW){1'b0}}};
      else
        sum_d = {s_big, e_work[EW-1:0], norm[FW-1:0]};
    end
  end

  assign out_valid_o = out_valid_q;
  assign sum_bits_o  = sum_q;

`ifndef SYNTHESIS
  // a held result must not change
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(sum_bits_o))
    else $error("result changed while stalled");
  // an accepted item reaches the result register when the way is clear
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_adv |=> out_valid_q)
    else $error("item lost between stages");
  // no acceptance while the pipe is full and stalled
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("accepted into a full pipe");
`endif
endmodule

/* rtl/core/dfa_lzc.sv */
// leading zero count for the difference significand
module dfa_lzc (
  input  logic [dfa_pkg::SigW-1:0] value_i,
  output logic [dfa_pkg::ShW-1:0]  count_o
);
  // tree reduction over a 64 bit padded word
  logic [63:0] pad;
  logic [5:0]  cnt;
  always_comb begin
    pad = {value_i, {(64 - dfa_pkg::SigW){1'b1}}};
    cnt[5] = (pad[63:32] == '0);
    if (cnt[5]) pad = {pad[31:0], 32'hffff_ffff};
    cnt[4] = (pad[63:48] == '0);
    if (cnt[4]) pad = {pad[47:0], 16'hffff};
    cnt[3] = (pad[63:56] == '0);
    if (cnt[3]) pad = {pad[55:0], 8'hff};
    cnt[2] = (pad[63:60] == '0);
    if (cnt[2]) pad = {pad[59:0], 4'hf};
    cnt[1] = (pad[63:62] == '0);
    if (cnt[1]) pad = {pad[61:0], 2'h3};
    cnt[0] = ~pad[63];
    count_o = cnt[dfa_pkg::ShW-1:0];
  end
endmodule
